// ----- hdl/vbdc_pkg.sv -----
// Package for the volume brick downsample and range cull core.
// Holds widths, store geometry, command and state codes, and factor helpers.
// No dependencies.
`default_nettype none

package vbdc_pkg;

    localparam int DATA_W      = 32;
    localparam int COORD_W     = 6;
    localparam int LEVEL_W     = 3;
    localparam int CMD_W       = 2;
    localparam int FACTOR_W    = 4;
    localparam int THRESH_W    = 31;
    localparam int DIV_W       = 10;
    localparam int CNT_W       = 5;

    localparam int LEVEL_DIM   = 64;
    localparam int COARSE_DIM  = 32;
    localparam int COARSE_BITS = $clog2(COARSE_DIM);
    localparam int CELL_ADDR_W = 3 * COARSE_BITS;
    localparam int STORE_CELLS = COARSE_DIM * COARSE_DIM * COARSE_DIM;

    localparam int S_DATA_W    = 56;
    localparam int M_DATA_W    = 104;

    localparam logic KIND_VERDICT  = 1'b0;
    localparam logic KIND_READ     = 1'b1;

    localparam logic REG_REFINE    = 1'b0;
    localparam logic REG_THRESHOLD = 1'b1;

    localparam logic [FACTOR_W-1:0] REFINE_RESET = 4'd2;

    localparam logic signed [DATA_W-1:0] MAX_S32 = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] MIN_S32 = 32'sh8000_0000;

    typedef enum logic [CMD_W-1:0] {
        CMD_VOXEL = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV_X,
        S_DIV_Y,
        S_DIV_Z,
        S_DIV_V,
        S_FETCH,
        S_ACCUM,
        S_EMIT,
        S_RD_WAIT,
        S_RD_OUT
    } state_t;

    function automatic logic [FACTOR_W-1:0] clamp_factor(input logic [FACTOR_W-1:0] f);
        logic [FACTOR_W-1:0] r;
        if (f < 4'd2)
            r = 4'd2;
        else if (f > 4'd8)
            r = 4'd8;
        else
            r = f;
        return r;
    endfunction

    function automatic logic [DIV_W-1:0] factor_cube(input logic [FACTOR_W-1:0] r);
        logic [DIV_W-1:0] c;
        unique case (r)
            4'd2:    c = 10'd8;
            4'd3:    c = 10'd27;
            4'd4:    c = 10'd64;
            4'd5:    c = 10'd125;
            4'd6:    c = 10'd216;
            4'd7:    c = 10'd343;
            4'd8:    c = 10'd512;
            default: c = 10'd8;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/volume_brick_downsample_cull_core.sv -----
// Volume brick downsample and range cull core: box-filter accumulation into a
// coarse store, per-brick min/max and keep verdict, store read and clear.
// Depends on vbdc_pkg and vbdc_ram.
// Voxel item: one shared restoring divider, one quotient bit a cycle, gives 6
// bits each for x/r, y/r, z/r and 32 bits for |v|/r^3; S_FETCH and S_ACCUM follow
// if the cell is in the store, then S_EMIT registers a last voxel's verdict once
// the output is free. Read item: result registered via S_RD_WAIT and S_RD_OUT.
// Clear item: the cell is written on accept. After reset the store is zeroed,
// one cell a cycle, with s_tready low; configuration writes are taken throughout.
`default_nettype none

module volume_brick_downsample_cull_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // voxel_value, coord_x, coord_y, coord_z, level, zero pad
    input  wire logic [vbdc_pkg::S_DATA_W-1:0]  s_tdata,
    // cmd
    input  wire logic [vbdc_pkg::CMD_W-1:0]     s_tuser,
    input  wire logic                           s_tlast,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // keep, brick_low, brick_high, cell_value, zero pad
    output logic      [vbdc_pkg::M_DATA_W-1:0]  m_tdata,
    // kind
    output logic                                m_tuser,
    input  wire logic                           cfg_we,
    input  wire logic                           cfg_index,
    input  wire logic [vbdc_pkg::THRESH_W-1:0]  cfg_wdata
);

    import vbdc_pkg::*;

    state_t state_reg, state_next;

    logic [FACTOR_W-1:0]     refine_reg, refine_next;
    logic [THRESH_W-1:0]     thresh_reg, thresh_next;
    logic signed [DATA_W-1:0] run_min_reg, run_min_next;
    logic signed [DATA_W-1:0] run_max_reg, run_max_next;
    logic [CELL_ADDR_W-1:0]  clr_reg, clr_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    out_valid_reg, out_valid_next;

    logic [DIV_W-1:0]        rem_reg, rem_next;
    logic [DATA_W-1:0]       num_reg, num_next;
    logic [COORD_W-1:0]      cx_reg, cx_next;
    logic [COORD_W-1:0]      cy_reg, cy_next;
    logic [COORD_W-1:0]      y_reg, y_next;
    logic [COORD_W-1:0]      z_reg, z_next;
    logic signed [DATA_W-1:0] voxel_reg, voxel_next;
    logic signed [DATA_W-1:0] quot_reg, quot_next;
    logic [LEVEL_W-1:0]      level_reg, level_next;
    logic                    last_reg, last_next;
    logic                    in_lvl_reg, in_lvl_next;
    logic                    in_store_reg, in_store_next;
    logic [CELL_ADDR_W-1:0]  addr_reg, addr_next;

    logic                    out_kind_reg, out_kind_next;
    logic                    out_keep_reg, out_keep_next;
    logic signed [DATA_W-1:0] out_low_reg, out_low_next;
    logic signed [DATA_W-1:0] out_high_reg, out_high_next;
    logic signed [DATA_W-1:0] out_cell_reg, out_cell_next;

    logic signed [DATA_W-1:0] in_voxel;
    logic [COORD_W-1:0]      in_x, in_y, in_z;
    logic [LEVEL_W-1:0]      in_level;
    logic                    accept;
    logic                    in_cell_ok;
    logic                    out_free;

    logic [FACTOR_W-1:0]     r_eff;
    logic [DIV_W-1:0]        divisor;
    logic [DIV_W:0]          rem_sh;
    logic                    div_ge;
    logic [DIV_W-1:0]        rem_step;
    logic [DATA_W-1:0]       num_step;
    logic [DATA_W-1:0]       voxel_abs;
    logic [COORD_W-1:0]      cz_q;

    logic signed [DATA_W:0]  acc_sum;
    logic signed [DATA_W-1:0] acc_sat;
    logic signed [DATA_W:0]  range_wide;
    logic [THRESH_W-1:0]     range_sat;
    logic                    drop;

    logic                    ram_we;
    logic [CELL_ADDR_W-1:0]  ram_waddr;
    logic [DATA_W-1:0]       ram_wdata;
    logic [DATA_W-1:0]       ram_rdata;

    assign in_voxel = $signed(s_tdata[31:0]);
    assign in_x     = s_tdata[37:32];
    assign in_y     = s_tdata[43:38];
    assign in_z     = s_tdata[49:44];
    assign in_level = s_tdata[52:50];

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign in_cell_ok = (in_x < COARSE_DIM) && (in_y < COARSE_DIM) && (in_z < COARSE_DIM);

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {7'd0, out_cell_reg, out_high_reg, out_low_reg, out_keep_reg};

    assign r_eff     = clamp_factor(refine_reg);
    assign divisor   = (state_reg == S_DIV_V) ? factor_cube(r_eff) : DIV_W'(r_eff);
    assign rem_sh    = {rem_reg, num_reg[DATA_W-1]};
    assign div_ge    = rem_sh >= {1'b0, divisor};
    assign rem_step  = div_ge ? DIV_W'(rem_sh - {1'b0, divisor}) : rem_sh[DIV_W-1:0];
    assign num_step  = {num_reg[DATA_W-2:0], div_ge};
    assign voxel_abs = voxel_reg[DATA_W-1] ? DATA_W'(-voxel_reg) : DATA_W'(voxel_reg);
    assign cz_q      = num_step[COORD_W-1:0];

    assign acc_sum = {ram_rdata[DATA_W-1], ram_rdata} + {quot_reg[DATA_W-1], quot_reg};
    assign acc_sat = (acc_sum[DATA_W] != acc_sum[DATA_W-1])
                   ? (acc_sum[DATA_W] ? MIN_S32 : MAX_S32)
                   : acc_sum[DATA_W-1:0];

    assign range_wide = {run_max_reg[DATA_W-1], run_max_reg}
                      - {run_min_reg[DATA_W-1], run_min_reg};
    assign range_sat  = (range_wide[DATA_W] || range_wide[DATA_W-1])
                      ? {THRESH_W{1'b1}} : range_wide[THRESH_W-1:0];
    assign drop       = (level_reg != '0) && (range_sat <= thresh_reg);

    vbdc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STORE_CELLS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next    = state_reg;
        refine_next   = refine_reg;
        thresh_next   = thresh_reg;
        run_min_next  = run_min_reg;
        run_max_next  = run_max_reg;
        clr_next      = clr_reg;
        cnt_next      = cnt_reg;
        rem_next      = rem_reg;
        num_next      = num_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        y_next        = y_reg;
        z_next        = z_reg;
        voxel_next    = voxel_reg;
        quot_next     = quot_reg;
        level_next    = level_reg;
        last_next     = last_reg;
        in_lvl_next   = in_lvl_reg;
        in_store_next = in_store_reg;
        addr_next     = addr_reg;
        out_kind_next = out_kind_reg;
        out_keep_next = out_keep_reg;
        out_low_next  = out_low_reg;
        out_high_next = out_high_reg;
        out_cell_next = out_cell_reg;
        out_valid_next = out_valid_reg && !m_tready;
        ram_we        = 1'b0;
        ram_waddr     = addr_reg;
        ram_wdata     = '0;

        if (cfg_we)
        begin
            if (cfg_index == REG_REFINE)
                refine_next = cfg_wdata[FACTOR_W-1:0];
            else
                thresh_next = cfg_wdata;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == {CELL_ADDR_W{1'b1}})
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    priority case (s_tuser)
                        CMD_VOXEL:
                        begin
                            voxel_next  = in_voxel;
                            y_next      = in_y;
                            z_next      = in_z;
                            level_next  = in_level;
                            last_next   = s_tlast;
                            in_lvl_next = (in_x < LEVEL_DIM) && (in_y < LEVEL_DIM)
                                          && (in_z < LEVEL_DIM);
                            if (in_voxel < run_min_reg)
                                run_min_next = in_voxel;
                            if (in_voxel > run_max_reg)
                                run_max_next = in_voxel;
                            rem_next   = '0;
                            num_next   = {in_x, (DATA_W-COORD_W)'(0)};
                            cnt_next   = CNT_W'(COORD_W - 1);
                            state_next = S_DIV_X;
                        end
                        CMD_READ:
                        begin
                            addr_next     = {in_z[COARSE_BITS-1:0], in_y[COARSE_BITS-1:0],
                                             in_x[COARSE_BITS-1:0]};
                            in_store_next = in_cell_ok;
                            state_next    = S_RD_WAIT;
                        end
                        CMD_CLEAR:
                        begin
                            ram_we    = in_cell_ok;
                            ram_waddr = {in_z[COARSE_BITS-1:0], in_y[COARSE_BITS-1:0],
                                         in_x[COARSE_BITS-1:0]};
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_DIV_X, S_DIV_Y, S_DIV_Z, S_DIV_V:
            begin
                rem_next = rem_step;
                num_next = num_step;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    rem_next = '0;
                    priority case (state_reg)
                        S_DIV_X:
                        begin
                            cx_next    = num_step[COORD_W-1:0];
                            num_next   = {y_reg, (DATA_W-COORD_W)'(0)};
                            cnt_next   = CNT_W'(COORD_W - 1);
                            state_next = S_DIV_Y;
                        end
                        S_DIV_Y:
                        begin
                            cy_next    = num_step[COORD_W-1:0];
                            num_next   = {z_reg, (DATA_W-COORD_W)'(0)};
                            cnt_next   = CNT_W'(COORD_W - 1);
                            state_next = S_DIV_Z;
                        end
                        S_DIV_Z:
                        begin
                            addr_next     = {cz_q[COARSE_BITS-1:0], cy_reg[COARSE_BITS-1:0],
                                             cx_reg[COARSE_BITS-1:0]};
                            in_store_next = in_lvl_reg && (cx_reg < COARSE_DIM)
                                            && (cy_reg < COARSE_DIM) && (cz_q < COARSE_DIM);
                            num_next      = voxel_abs;
                            cnt_next      = CNT_W'(DATA_W - 1);
                            state_next    = S_DIV_V;
                        end
                        default:
                        begin
                            quot_next  = voxel_reg[DATA_W-1] ? $signed(-num_step)
                                                             : $signed(num_step);
                            state_next = in_store_reg ? S_FETCH : S_EMIT;
                        end
                    endcase
                end
            end
            S_FETCH:
            begin
                state_next = S_ACCUM;
            end
            S_ACCUM:
            begin
                ram_we     = 1'b1;
                ram_waddr  = addr_reg;
                ram_wdata  = acc_sat;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!last_reg)
                    state_next = S_IDLE;
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_VERDICT;
                    out_keep_next  = !drop;
                    out_low_next   = run_min_reg;
                    out_high_next  = run_max_reg;
                    out_cell_next  = '0;
                    run_min_next   = MAX_S32;
                    run_max_next   = MIN_S32;
                    state_next     = S_IDLE;
                end
            end
            S_RD_WAIT:
            begin
                state_next = S_RD_OUT;
            end
            S_RD_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_READ;
                    out_keep_next  = 1'b0;
                    out_low_next   = '0;
                    out_high_next  = '0;
                    out_cell_next  = in_store_reg ? $signed(ram_rdata) : '0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            refine_reg    <= REFINE_RESET;
            thresh_reg    <= '0;
            run_min_reg   <= MAX_S32;
            run_max_reg   <= MIN_S32;
            clr_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            refine_reg    <= refine_next;
            thresh_reg    <= thresh_next;
            run_min_reg   <= run_min_next;
            run_max_reg   <= run_max_next;
            clr_reg       <= clr_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg      <= rem_next;
        num_reg      <= num_next;
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        y_reg        <= y_next;
        z_reg        <= z_next;
        voxel_reg    <= voxel_next;
        quot_reg     <= quot_next;
        level_reg    <= level_next;
        last_reg     <= last_next;
        in_lvl_reg   <= in_lvl_next;
        in_store_reg <= in_store_next;
        addr_reg     <= addr_next;
        out_kind_reg <= out_kind_next;
        out_keep_reg <= out_keep_next;
        out_low_reg  <= out_low_next;
        out_high_reg <= out_high_next;
        out_cell_reg <= out_cell_next;
    end

`ifndef SYNTHESIS
    a_verdict_order: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == KIND_VERDICT) |-> (out_low_reg <= out_high_reg))
        else $error("verdict item with brick minimum above maximum");

    a_read_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == KIND_READ)
        |-> (!out_keep_reg && out_low_reg == '0 && out_high_reg == '0))
        else $error("read item carries verdict fields");

    a_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && s_tready) |-> (s_tvalid && s_tuser == CMD_CLEAR))
        else $error("store write in idle without a clear item");
`endif

endmodule

`default_nettype wire

// ----- hdl/vbdc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module vbdc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- tb/volume_brick_downsample_cull_core_test.sv -----
`timescale 1ns / 100ps
// Testbench for volume_brick_downsample_cull_core: streams voxel, read and clear items,
// predicts brick keep verdicts and coarse cell sums, and checks each result in order.
// Depends on vbdc_pkg and the core RTL.

module volume_brick_downsample_cull_core_test;

    import vbdc_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 64;
    localparam int DRAIN_LIMIT   = 20000;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [DATA_W-1:0]  value;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic [LEVEL_W-1:0] level;
        logic               last;
    } item_t;

    typedef struct packed {
        logic              kind;
        logic              keep;
        logic [DATA_W-1:0] low;
        logic [DATA_W-1:0] high;
        logic [DATA_W-1:0] cell_sum;
    } outcome_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic [CMD_W-1:0]      s_tuser;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready = 1'b1;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tuser;
    logic                  cfg_we;
    logic                  cfg_index;
    logic [THRESH_W-1:0]   cfg_wdata;

    logic [FACTOR_W-1:0]   factor_reg;
    logic [THRESH_W-1:0]   threshold_reg;
    int                    brick_min;
    int                    brick_max;
    int                    cell_sums [STORE_CELLS] = '{default: 0};
    outcome_t              pending_results [$];

    int                    failures;
    int                    verdicts_seen;
    int                    reads_seen;
    int                    items_sent;
    bit                    idling_enabled;
    int                    stall_left = 0;

    volume_brick_downsample_cull_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    initial
    begin
        #3_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic int unsigned effective_factor();
        if (factor_reg < 2)
            return 2;
        if (factor_reg > 8)
            return 8;
        return 32'(factor_reg);
    endfunction

    function automatic bit in_store(input int unsigned x, input int unsigned y,
                                    input int unsigned z);
        return x < COARSE_DIM && y < COARSE_DIM && z < COARSE_DIM;
    endfunction

    function automatic int cell_slot(input int unsigned x, input int unsigned y,
                                     input int unsigned z);
        return (z * COARSE_DIM + y) * COARSE_DIM + x;
    endfunction

    function automatic bit downsample_and_cull(input item_t it, output outcome_t res);
        int unsigned r;
        longint      sum;
        longint      span;
        int          v;
        res = '0;
        v = it.value;
        if (it.cmd == CMD_VOXEL)
        begin
            r = effective_factor();
            if (it.x < LEVEL_DIM && it.y < LEVEL_DIM && it.z < LEVEL_DIM &&
                in_store(it.x / r, it.y / r, it.z / r))
            begin
                sum = longint'(cell_sums[cell_slot(it.x / r, it.y / r, it.z / r)]) +
                      longint'(v) / longint'(r * r * r);
                if (sum > longint'(MAX_S32))
                    sum = longint'(MAX_S32);
                if (sum < longint'(MIN_S32))
                    sum = longint'(MIN_S32);
                cell_sums[cell_slot(it.x / r, it.y / r, it.z / r)] = int'(sum);
            end
            if (v < brick_min)
                brick_min = v;
            if (v > brick_max)
                brick_max = v;
            if (!it.last)
                return 0;
            span = longint'(brick_max) - longint'(brick_min);
            if (span > longint'(MAX_S32))
                span = longint'(MAX_S32);
            res.kind = KIND_VERDICT;
            res.keep = !(it.level != 0 && span <= longint'(threshold_reg));
            res.low  = brick_min;
            res.high = brick_max;
            brick_min = MAX_S32;
            brick_max = MIN_S32;
            return 1;
        end
        if (it.cmd == CMD_READ)
        begin
            res.kind = KIND_READ;
            if (in_store(it.x, it.y, it.z))
                res.cell_sum = cell_sums[cell_slot(it.x, it.y, it.z)];
            return 1;
        end
        if (it.cmd == CMD_CLEAR && in_store(it.x, it.y, it.z))
            cell_sums[cell_slot(it.x, it.y, it.z)] = 0;
        return 0;
    endfunction

    // receiver: random stall bursts while idling is enabled
    always @(posedge clk)
    begin
        if (stall_left > 0)
            stall_left--;
        else if (idling_enabled && $urandom_range(0, 9) == 0)
            stall_left = $urandom_range(1, 17);
        m_tready <= (stall_left == 0);
    end

    task automatic compare_field(input string name, input logic [DATA_W-1:0] want,
                                 input logic [DATA_W-1:0] got);
        if (got !== want)
        begin
            failures++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin : check_results
        outcome_t want;
        outcome_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.kind     = m_tuser;
            got.keep     = m_tdata[0];
            got.low      = m_tdata[32:1];
            got.high     = m_tdata[64:33];
            got.cell_sum = m_tdata[96:65];
            if (pending_results.size() == 0)
            begin
                failures++;
                $display("%0t: unexpected result, expected none, actual kind %0d data %h",
                         $time, got.kind, m_tdata);
            end
            else
            begin
                want = pending_results.pop_front();
                compare_field("kind", DATA_W'(want.kind), DATA_W'(got.kind));
                compare_field("keep", DATA_W'(want.keep), DATA_W'(got.keep));
                compare_field("brick_low", want.low, got.low);
                compare_field("brick_high", want.high, got.high);
                compare_field("cell_value", want.cell_sum, got.cell_sum);
                if (want.kind == KIND_VERDICT)
                    verdicts_seen++;
                else
                    reads_seen++;
            end
        end
    end

    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] value,
                             input int x, input int y, input int z, input int level,
                             input bit last);
        item_t    it;
        outcome_t res;
        it.cmd   = cmd;
        it.value = value;
        it.x     = x[COORD_W-1:0];
        it.y     = y[COORD_W-1:0];
        it.z     = z[COORD_W-1:0];
        it.level = level[LEVEL_W-1:0];
        it.last  = last;
        if (idling_enabled && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'({it.level, it.z, it.y, it.x, it.value});
        s_tuser  <= it.cmd;
        s_tlast  <= it.last;
        do
            @(posedge clk);
        while (!s_tready);
        if (downsample_and_cull(it, res))
            pending_results.push_back(res);
        if (cmd != CMD_UNUSED)
            items_sent++;
    endtask

    // drain outstanding results, then hold off for voxel latency
    task automatic settle();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_results.size() != 0)
        begin
            failures++;
            $display("%0t: %0d results never arrived", $time, pending_results.size());
            pending_results.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic [FACTOR_W-1:0] factor,
                              input logic [THRESH_W-1:0] threshold);
        cfg_we    <= 1'b1;
        cfg_index <= REG_REFINE;
        cfg_wdata <= (THRESH_W'($urandom) << FACTOR_W) | THRESH_W'(factor);
        @(posedge clk);
        cfg_index <= REG_THRESHOLD;
        cfg_wdata <= threshold;
        @(posedge clk);
        cfg_we <= 1'b0;
        factor_reg    = factor;
        threshold_reg = threshold;
    endtask

    function automatic void pick_cell(input int fx, input int fy, input int fz,
                                      output int cx, output int cy, output int cz);
        int unsigned r;
        r = effective_factor();
        case ($urandom_range(0, 9))
            0, 1:
            begin
                cx = $urandom_range(0, COARSE_DIM - 1);
                cy = $urandom_range(0, COARSE_DIM - 1);
                cz = $urandom_range(0, COARSE_DIM - 1);
            end
            2:
            begin
                cx = $urandom_range(0, 63);
                cy = $urandom_range(0, 63);
                cz = $urandom_range(0, 63);
                case ($urandom_range(0, 2))
                    0:       cx = $urandom_range(COARSE_DIM, 63);
                    1:       cy = $urandom_range(COARSE_DIM, 63);
                    default: cz = $urandom_range(COARSE_DIM, 63);
                endcase
            end
            default:
            begin
                cx = fx / r;
                cy = fy / r;
                cz = fz / r;
            end
        endcase
    endfunction

    task automatic test_store_after_reset();
        send_item(CMD_READ, 0, 0, 0, 0, 0, 0);
        send_item(CMD_READ, '1, 31, 31, 31, 7, 1);
        send_item(CMD_READ, 0, 32, 0, 0, 0, 0);
        send_item(CMD_READ, 0, 0, 63, 0, 0, 0);
        send_item(CMD_UNUSED, '1, 63, 63, 63, 7, 1);
        send_item(CMD_CLEAR, 0, 0, 0, 40, 0, 1);
    endtask

    task automatic test_truncation_and_range();
        send_item(CMD_VOXEL, -15, 1, 1, 1, 0, 1);
        send_item(CMD_VOXEL, 15, 0, 0, 0, 5, 0);
        send_item(CMD_VOXEL, 15, 1, 0, 1, 5, 1);
        send_item(CMD_READ, 0, 0, 0, 0, 0, 0);
        send_item(CMD_VOXEL, MIN_S32, 63, 63, 63, 7, 0);
        send_item(CMD_VOXEL, MAX_S32, 62, 62, 62, 7, 1);
    endtask

    task automatic test_saturation();
        settle();
        set_config(4'd2, '1);
        send_item(CMD_VOXEL, MIN_S32, 0, 0, 2, 4, 0);
        for (int k = 0; k < 9; k++)
            send_item(CMD_VOXEL, MAX_S32, 63, 62, 63, 4, k == 8);
        send_item(CMD_READ, 0, 31, 31, 31, 0, 0);
        send_item(CMD_CLEAR, 0, 31, 31, 31, 0, 0);
        send_item(CMD_READ, 0, 31, 31, 31, 0, 0);
    endtask

    task automatic run_random_items(input int target);
        int                first;
        int                pick;
        int                len;
        int                lvl;
        int                fx;
        int                fy;
        int                fz;
        int                cx;
        int                cy;
        int                cz;
        int unsigned       spread;
        logic [DATA_W-1:0] base;
        logic [DATA_W-1:0] v;
        first = items_sent;
        fx = $urandom_range(0, 63);
        fy = $urandom_range(0, 63);
        fz = $urandom_range(0, 63);
        while (items_sent - first < target)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                fx = $urandom_range(0, 63);
                fy = $urandom_range(0, 63);
                fz = $urandom_range(0, 63);
            end
            pick = $urandom_range(0, 99);
            lvl  = $urandom_range(0, 7);
            if (pick < 60)
            begin
                len  = $urandom_range(1, 6);
                base = $urandom;
                case ($urandom_range(0, 3))
                    0:       spread = 0;
                    1:       spread = 32'(threshold_reg);
                    2:       spread = threshold_reg + 1 + $urandom_range(0, 1 << 20);
                    default: spread = '1;
                endcase
                for (int k = 0; k < len; k++)
                begin
                    if (k == 0)
                        v = base;
                    else if (k == len - 1)
                        v = base + spread;
                    else
                        v = base + $urandom_range(0, spread);
                    send_item(CMD_VOXEL, v, (fx + $urandom_range(0, 3)) % 64,
                              (fy + $urandom_range(0, 3)) % 64,
                              (fz + $urandom_range(0, 3)) % 64, lvl, k == len - 1);
                end
            end
            else if (pick < 68)
            begin
                // push one cell toward saturation, then read it back
                base = $urandom_range(0, 1) ? MAX_S32 : MIN_S32;
                for (int k = 0; k < 10; k++)
                    send_item(CMD_VOXEL, base, fx, fy, fz, lvl, k == 9);
                send_item(CMD_READ, $urandom, fx / effective_factor(),
                          fy / effective_factor(), fz / effective_factor(), lvl, 0);
            end
            else if (pick < 85)
            begin
                pick_cell(fx, fy, fz, cx, cy, cz);
                send_item(CMD_READ, $urandom, cx, cy, cz, lvl, 1'($urandom_range(0, 1)));
            end
            else if (pick < 93)
            begin
                pick_cell(fx, fy, fz, cx, cy, cz);
                send_item(CMD_CLEAR, $urandom, cx, cy, cz, lvl, 1'($urandom_range(0, 1)));
            end
            else
            begin
                send_item(CMD_UNUSED, $urandom, $urandom_range(0, 63), $urandom_range(0, 63),
                          $urandom_range(0, 63), lvl, 1'($urandom_range(0, 1)));
            end
        end
    endtask

    task automatic test_random_traffic();
        logic [FACTOR_W-1:0] factor;
        logic [THRESH_W-1:0] threshold;
        for (int phase = 0; phase < 8; phase++)
        begin
            settle();
            case (phase)
                0:       factor = 4'd0;
                1:       factor = 4'd8;
                2:       factor = 4'd15;
                3:       factor = 4'd3;
                4:       factor = 4'd1;
                5:       factor = 4'd6;
                6:       factor = 4'd9;
                default: factor = FACTOR_W'($urandom_range(2, 8));
            endcase
            case (phase % 4)
                0:       threshold = (phase == 0) ? '0 : THRESH_W'($urandom);
                1:       threshold = '1;
                default: threshold = THRESH_W'($urandom_range(0, 32'h000F_FFFF));
            endcase
            set_config(factor, threshold);
            idling_enabled = (phase != 3 && phase < 6);
            run_random_items(80);
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = CMD_VOXEL;
        s_tlast        = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = REG_REFINE;
        cfg_wdata      = '0;
        failures       = 0;
        verdicts_seen  = 0;
        reads_seen     = 0;
        items_sent     = 0;
        idling_enabled = 1'b1;
        factor_reg     = REFINE_RESET;
        threshold_reg  = '0;
        brick_min      = MAX_S32;
        brick_max      = MIN_S32;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_store_after_reset();
        test_truncation_and_range();
        test_saturation();
        test_random_traffic();
        settle();

        $display("Sent %0d items over 8 refine/threshold settings; checked %0d brick verdicts",
                 items_sent, verdicts_seen);
        $display("and %0d cell reads, with %0d failures.", reads_seen, failures);
        if (failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
